FILE: hdl/mava_pkg.sv
// mava_pkg: shared widths, sequencer states and shift codes for the mesh
// area and volume accumulator; no dependencies
package mava_pkg;

    localparam int AREA_W  = 48;
    localparam int VOL_W   = 64;
    localparam int VOUT_W  = 63;
    localparam int TALLY_W = 24;
    localparam int DIV_STEPS = 8;
    localparam int DIGIT_W = 8;
    localparam int MUL_STEPS = 15;
    localparam logic [3:0] DIVISOR = 4'd6;
    // floor(t/6) == (t*683)>>12 for every t below 6*256
    localparam logic [10:0] RECIP_SIX = 11'd683;
    localparam int RECIP_SHIFT = 12;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_ROOT,
        ST_UPDATE,
        ST_DIV,
        ST_EMIT
    } back_state_t;

    // alignment of one partial product inside its accumulator
    typedef enum logic [1:0] {
        SH_NONE,
        SH_HALF,
        SH_HALF_X2,
        SH_FULL
    } shift_t;

endpackage

FILE: hdl/mava_front.sv
// mava_front: edge vectors, cross product and the cofactors of the triple
// product for one triangle word; uses mava_pkg
module mava_front
    import mava_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] v0_x,
    input  logic signed [COORD_BITS-1:0] v0_y,
    input  logic signed [COORD_BITS-1:0] v0_z,
    input  logic signed [COORD_BITS-1:0] v1_x,
    input  logic signed [COORD_BITS-1:0] v1_y,
    input  logic signed [COORD_BITS-1:0] v1_z,
    input  logic signed [COORD_BITS-1:0] v2_x,
    input  logic signed [COORD_BITS-1:0] v2_y,
    input  logic signed [COORD_BITS-1:0] v2_z,
    input  logic                         last_triangle,
    output logic [15*COORD_BITS+12:0]    word
);

    localparam int C  = COORD_BITS;
    localparam int KW = 2*C + 3;
    localparam int MD = 2*C + 1;

    logic signed [C:0]    ux, uy, uz, wx, wy, wz;
    logic signed [2*C+1:0] pa, pb, pc, pd, pe, pf;
    logic signed [KW-1:0] kx, ky, kz;
    logic signed [2*C-1:0] qa, qb, qc, qd, qe, qf;
    logic signed [MD-1:0] mx, my, mz;

    // edge vectors
    always_comb
    begin
        ux = {v1_x[C-1], v1_x} - {v0_x[C-1], v0_x};
        uy = {v1_y[C-1], v1_y} - {v0_y[C-1], v0_y};
        uz = {v1_z[C-1], v1_z} - {v0_z[C-1], v0_z};
        wx = {v2_x[C-1], v2_x} - {v0_x[C-1], v0_x};
        wy = {v2_y[C-1], v2_y} - {v0_y[C-1], v0_y};
        wz = {v2_z[C-1], v2_z} - {v0_z[C-1], v0_z};
    end

    // cross product of the edges
    always_comb
    begin
        pa = uy * wz;
        pb = uz * wy;
        pc = uz * wx;
        pd = ux * wz;
        pe = ux * wy;
        pf = uy * wx;
        kx = KW'(pa) - KW'(pb);
        ky = KW'(pc) - KW'(pd);
        kz = KW'(pe) - KW'(pf);
    end

    // v1 x v2, dotted with v0 later in the back end
    always_comb
    begin
        qa = v1_y * v2_z;
        qb = v1_z * v2_y;
        qc = v1_z * v2_x;
        qd = v1_x * v2_z;
        qe = v1_x * v2_y;
        qf = v1_y * v2_x;
        mx = MD'(qa) - MD'(qb);
        my = MD'(qc) - MD'(qd);
        mz = MD'(qe) - MD'(qf);
    end

    assign word = {last_triangle, v0_x, v0_y, v0_z, mx, my, mz, kx, ky, kz};

endmodule

FILE: hdl/mava_queue.sv
// mava_queue: two-entry queue of classified triangle words between front
// and back; no dependencies
module mava_queue
#(
    parameter int WIDTH = 253
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic             rd_empty,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_wr, do_rd;

    // handshake qualifiers and pointer updates
    always_comb
    begin
        do_wr       = wr_en && (count_reg != 2'd2);
        do_rd       = rd_en && (count_reg != 2'd0);
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign full     = (count_reg == 2'd2);
    assign rd_empty = (count_reg == 2'd0);
    assign rd_data  = mem[rd_ptr_reg];

endmodule

FILE: hdl/mava_back.sv
// mava_back: sequencer with one shared multiplier, bit-serial square root,
// saturating sums, divide by six and the result register; uses mava_pkg
module mava_back
    import mava_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [15*COORD_BITS+12:0] q_data,
    input  logic                      q_empty,
    output logic                      q_pop,
    output logic                      empty,
    input  logic                      pop,
    output logic [AREA_W-1:0]         total_area,
    output logic [VOUT_W-1:0]         total_volume,
    output logic [TALLY_W-1:0]        triangle_total
);

    localparam int C   = COORD_BITS;
    localparam int MW  = C + 1;
    localparam int PW  = 2*MW + 2;
    localparam int KW  = 2*C + 3;
    localparam int MD  = 2*C + 1;
    localparam int RW  = 2*C + 3;
    localparam int SQW = 2*RW;
    localparam int AW  = SQW + 2;
    localparam int VW  = 3*C + 4;
    localparam int SW  = ((VW > VOL_W) ? VW : VOL_W) + 1;
    localparam int ASW = ((RW > AREA_W) ? RW : AREA_W) + 1;
    localparam int WW  = 15*C + 13;
    localparam int RCW = $clog2(RW);
    localparam int DTW = DIGIT_W + 3;
    localparam int DPW = 2*DTW;

    back_state_t state_reg, state_next;

    logic [WW-1:0]          item_reg;
    logic [3:0]             step_reg;
    logic signed [PW-1:0]   prod_reg;
    shift_t                 psh_reg;
    logic                   ptgt_reg;
    logic signed [AW-1:0]   len2_reg;
    logic signed [VW-1:0]   tri_reg;
    logic [SQW-1:0]         rad_reg;
    logic [RW+1:0]          rem_reg;
    logic [RW-1:0]          root_reg;
    logic [RCW-1:0]         rcnt_reg;
    logic [AREA_W-1:0]      area_sum_reg;
    logic [VOL_W-1:0]       volume_sum_reg;
    logic [TALLY_W-1:0]     tally_reg;
    logic [VOL_W-1:0]       num_reg;
    logic [2:0]             drem_reg;
    logic [2:0]             dcnt_reg;
    logic [AREA_W-1:0]      res_area_reg;
    logic [TALLY_W-1:0]     res_tally_reg;
    logic                   out_valid_reg;
    logic [AREA_W-1:0]      out_area_reg;
    logic [VOUT_W-1:0]      out_vol_reg;
    logic [TALLY_W-1:0]     out_tally_reg;

    logic                   load_item, item_last;
    logic                   mul_done, root_done, div_done, out_free;
    logic signed [KW-1:0]   kx, ky, kz, ksel;
    logic signed [MD-1:0]   mx, my, mz, msel;
    logic signed [C-1:0]    ax, ay, az, asel;
    logic signed [MW:0]     opa, opb;
    shift_t                 sh;
    logic                   tgt;
    logic signed [AW-1:0]   pext_a, padd_a;
    logic signed [VW-1:0]   pext_v, padd_v;
    logic [RW+1:0]          rem_try, trial;
    logic [ASW-1:0]         area_add;
    logic [AREA_W-1:0]      area_new;
    logic signed [SW-1:0]   vol_add;
    logic [VOL_W-1:0]       vol_new, vol_mag;
    logic [TALLY_W-1:0]     tally_new;
    logic [DTW-1:0]         dtry, dsub;
    logic [DPW-1:0]         dprod;
    logic [DIGIT_W-1:0]     dq;

    // field split of the queue word
    always_comb
    begin
        {item_last, ax, ay, az, mx, my, mz, kx, ky, kz} = item_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (!q_empty) state_next = ST_MUL;
            ST_MUL:    if (mul_done) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_ROOT;
            ST_ROOT:   if (root_done) state_next = ST_UPDATE;
            ST_UPDATE: state_next = item_last ? ST_DIV : ST_IDLE;
            ST_DIV:    if (div_done) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        load_item = 1'b0;
        case (state_reg)
            ST_IDLE: load_item = !q_empty;
            default: load_item = 1'b0;
        endcase
    end

    assign mul_done  = (step_reg == 4'(MUL_STEPS - 1));
    assign root_done = (rcnt_reg == '0);
    assign div_done  = (dcnt_reg == 3'(DIV_STEPS - 1));
    assign out_free  = !out_valid_reg;
    assign q_pop     = load_item;

    // operand select for the shared multiplier
    always_comb
    begin
        ksel = kx;
        msel = mx;
        asel = ax;
        case (step_reg)
            4'd3, 4'd4, 4'd5:    ksel = ky;
            4'd6, 4'd7, 4'd8:    ksel = kz;
            default:             ksel = kx;
        endcase
        case (step_reg)
            4'd11, 4'd12:        begin msel = my; asel = ay; end
            4'd13, 4'd14:        begin msel = mz; asel = az; end
            default:             begin msel = mx; asel = ax; end
        endcase
        opa = '0;
        opb = '0;
        sh  = SH_NONE;
        tgt = 1'b0;
        case (step_reg)
            4'd0, 4'd3, 4'd6:
            begin
                opa = {1'b0, ksel[MW-1:0]};
                opb = {1'b0, ksel[MW-1:0]};
            end
            4'd1, 4'd4, 4'd7:
            begin
                opa = {1'b0, ksel[MW-1:0]};
                opb = ksel[KW-1:MW];
                sh  = SH_HALF_X2;
            end
            4'd2, 4'd5, 4'd8:
            begin
                opa = ksel[KW-1:MW];
                opb = ksel[KW-1:MW];
                sh  = SH_FULL;
            end
            4'd9, 4'd11, 4'd13:
            begin
                opa = {{(MW+1-C){asel[C-1]}}, asel};
                opb = {1'b0, msel[MW-1:0]};
                tgt = 1'b1;
            end
            4'd10, 4'd12, 4'd14:
            begin
                opa = {{(MW+1-C){asel[C-1]}}, asel};
                opb = {{(MW+1-(MD-MW)){msel[MD-1]}}, msel[MD-1:MW]};
                sh  = SH_HALF;
                tgt = 1'b1;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // align the registered product into its accumulator
    always_comb
    begin
        pext_a = AW'(prod_reg);
        pext_v = VW'(prod_reg);
        case (psh_reg)
            SH_HALF:    begin padd_a = pext_a <<< MW;       padd_v = pext_v <<< MW; end
            SH_HALF_X2: begin padd_a = pext_a <<< (MW + 1); padd_v = pext_v <<< (MW + 1); end
            SH_FULL:    begin padd_a = pext_a <<< (2*MW);   padd_v = pext_v <<< (2*MW); end
            default:    begin padd_a = pext_a;              padd_v = pext_v; end
        endcase
    end

    // one root digit: bring down two radicand bits, try to subtract
    always_comb
    begin
        rem_try = {rem_reg[RW-1:0], rad_reg[SQW-1:SQW-2]};
        trial   = {root_reg, 2'b01};
    end

    // saturating sums
    always_comb
    begin
        area_add = ASW'(area_sum_reg) + ASW'(root_reg >> 1);
        if (area_add > ASW'({AREA_W{1'b1}}))
            area_new = {AREA_W{1'b1}};
        else
            area_new = area_add[AREA_W-1:0];
        vol_add = SW'($signed(volume_sum_reg)) + SW'(tri_reg);
        if ((&vol_add[SW-1:VOL_W-1]) || !(|vol_add[SW-1:VOL_W-1]))
            vol_new = vol_add[VOL_W-1:0];
        else if (vol_add[SW-1])
            vol_new = {1'b1, {(VOL_W-1){1'b0}}};
        else
            vol_new = {1'b0, {(VOL_W-1){1'b1}}};
        vol_mag   = vol_new[VOL_W-1] ? (~vol_new + 1'b1) : vol_new;
        tally_new = (&tally_reg) ? tally_reg : tally_reg + 1'b1;
    end

    // one quotient byte by reciprocal multiply, remainder carried to the next
    always_comb
    begin
        dtry  = {drem_reg, num_reg[VOL_W-1 -: DIGIT_W]};
        dprod = DPW'(dtry) * DPW'(RECIP_SIX);
        dq    = dprod[RECIP_SHIFT +: DIGIT_W];
        dsub  = dtry - DTW'(dq) * DTW'(DIVISOR);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            area_sum_reg   <= '0;
            volume_sum_reg <= '0;
            tally_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPDATE)
            begin
                area_sum_reg   <= item_last ? '0 : area_new;
                volume_sum_reg <= item_last ? '0 : vol_new;
                tally_reg      <= item_last ? '0 : tally_new;
            end
            if (state_reg == ST_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            item_reg <= q_data;
            step_reg <= '0;
            len2_reg <= '0;
            tri_reg  <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= opa * opb;
            psh_reg  <= sh;
            ptgt_reg <= tgt;
            step_reg <= step_reg + 4'd1;
        end
        if (state_reg == ST_DRAIN || (state_reg == ST_MUL && step_reg != '0))
        begin
            if (ptgt_reg)
                tri_reg <= tri_reg + padd_v;
            else
                len2_reg <= len2_reg + padd_a;
        end
        if (state_reg == ST_DRAIN)
        begin
            rad_reg  <= len2_reg[SQW-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
            rcnt_reg <= RCW'(RW - 1);
        end
        if (state_reg == ST_ROOT)
        begin
            rad_reg  <= rad_reg << 2;
            rcnt_reg <= rcnt_reg - 1'b1;
            if (rem_try >= trial)
            begin
                rem_reg  <= rem_try - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_try;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
        if (state_reg == ST_UPDATE)
        begin
            res_area_reg  <= area_new;
            res_tally_reg <= tally_new;
            num_reg       <= vol_mag;
            drem_reg      <= '0;
            dcnt_reg      <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            dcnt_reg <= dcnt_reg + 3'd1;
            drem_reg <= dsub[2:0];
            num_reg  <= {num_reg[VOL_W-DIGIT_W-1:0], dq};
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_area_reg  <= res_area_reg;
            out_vol_reg   <= num_reg[VOUT_W-1:0];
            out_tally_reg <= res_tally_reg;
        end
    end

    assign empty          = !out_valid_reg;
    assign total_area     = out_area_reg;
    assign total_volume   = out_vol_reg;
    assign triangle_total = out_tally_reg;

endmodule

FILE: hdl/mesh_area_volume_accumulator_top.sv
// mesh_area_volume_accumulator_top: top level joining front, queue and back
// end; uses mava_pkg, mava_front, mava_queue, mava_back
//
// Usage: triangle words enter through push/full; a word is taken on a clock
// edge with push high and full low. Each word carries three vertices and the
// last_triangle mark. Results leave through empty/pop: while empty is low the
// oldest result sits on total_area, total_volume and triangle_total and is
// taken on an edge with pop high.
// The back end handles each word in steps: a load, 15 shared-multiplier
// steps, a drain, 2*COORD_BITS+3 square root digits at one per cycle and an
// update. A last word adds a divide by six, one quotient byte per cycle, and
// then a move into the result register.
// A two-entry queue lets the front take words while the back end works.
// Stall: if the result register is still held, the back end waits in its
// emit step and the queue fills, then full rises.
// Reset: all sums, the tally and the queue clear and the result register is
// marked empty; no clearing pass is needed.
module mesh_area_volume_accumulator_top
    import mava_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] v0_x,
    input  logic signed [COORD_BITS-1:0] v0_y,
    input  logic signed [COORD_BITS-1:0] v0_z,
    input  logic signed [COORD_BITS-1:0] v1_x,
    input  logic signed [COORD_BITS-1:0] v1_y,
    input  logic signed [COORD_BITS-1:0] v1_z,
    input  logic signed [COORD_BITS-1:0] v2_x,
    input  logic signed [COORD_BITS-1:0] v2_y,
    input  logic signed [COORD_BITS-1:0] v2_z,
    input  logic                         last_triangle,
    output logic                         empty,
    input  logic                         pop,
    output logic [AREA_W-1:0]            total_area,
    output logic [VOUT_W-1:0]            total_volume,
    output logic [TALLY_W-1:0]           triangle_total
);

    localparam int WW = 15*COORD_BITS + 13;

    logic [WW-1:0] front_word, q_word;
    logic          q_empty;
    logic          q_pop;

    // classify the incoming triangle
    mava_front #(.COORD_BITS(COORD_BITS)) u_front (
        .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
        .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
        .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
        .last_triangle(last_triangle),
        .word(front_word)
    );

    // queue between front and back end
    mava_queue #(.WIDTH(WW)) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(push),
        .wr_data(front_word),
        .full(full),
        .rd_en(q_pop),
        .rd_empty(q_empty),
        .rd_data(q_word)
    );

    // back end sequencer
    mava_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_data(q_word),
        .q_empty(q_empty),
        .q_pop(q_pop),
        .empty(empty),
        .pop(pop),
        .total_area(total_area),
        .total_volume(total_volume),
        .triangle_total(triangle_total)
    );

    // a result always counts at least its last triangle
    assert property (@(posedge clk) disable iff (!rst_n) !empty |-> triangle_total != '0)
        else $error("result with zero triangle count");

    // quotient of a 64-bit magnitude by six stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> total_volume <= 63'h1555555555555555)
        else $error("volume quotient out of range");

endmodule

FILE: test/tb_top.sv
// tb_top: self-checking testbench for mesh_area_volume_accumulator_top; feeds
// directed and random triangle words and checks mesh results against a predictor
// depends on mava_pkg and mesh_area_volume_accumulator_top
module tb_top;
    import mava_pkg::*;

    localparam int CB = 16;
    localparam longint LIMIT = 64'd3000000;
    localparam logic [AREA_W-1:0] AREA_TOP = {AREA_W{1'b1}};
    localparam logic [TALLY_W-1:0] TALLY_TOP = {TALLY_W{1'b1}};

    typedef struct {
        logic signed [CB-1:0] c [9];
        logic last;
    } tri_word_t;

    typedef struct {
        logic [AREA_W-1:0] area;
        logic [VOUT_W-1:0] volume;
        logic [TALLY_W-1:0] count;
    } mesh_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [CB-1:0] vtx [9];
    logic last_triangle = 1'b0;
    logic [AREA_W-1:0] total_area;
    logic [VOUT_W-1:0] total_volume;
    logic [TALLY_W-1:0] triangle_total;

    tri_word_t pending_words[$];
    mesh_result_t expected_meshes[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    longint cycles = 0;

    // predictor state
    logic [AREA_W-1:0] area_acc = '0;
    logic signed [VOL_W-1:0] volume_acc = '0;
    logic [TALLY_W-1:0] tally_acc = '0;

    always #5 clk = ~clk;

    mesh_area_volume_accumulator_top DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .v0_x(vtx[0]), .v0_y(vtx[1]), .v0_z(vtx[2]),
        .v1_x(vtx[3]), .v1_y(vtx[4]), .v1_z(vtx[5]),
        .v2_x(vtx[6]), .v2_y(vtx[7]), .v2_z(vtx[8]),
        .last_triangle(last_triangle), .empty(empty), .pop(pop),
        .total_area(total_area), .total_volume(total_volume),
        .triangle_total(triangle_total)
    );

    // integer square root, one digit per step
    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= n)
                r = t;
        end
        return r;
    endfunction

    // fold one triangle into the sums; queue a result on a last word
    task automatic accumulate_triangle(tri_word_t w);
        logic signed [63:0] a [9];
        logic signed [63:0] ux, uy, uz, wx, wy, wz, kx, ky, kz;
        logic signed [127:0] trip, vsum;
        logic [127:0] len2;
        logic [63:0] half_root, vmag;
        logic [AREA_W:0] asum;
        mesh_result_t r;
        for (int i = 0; i < 9; i++)
        begin
            a[i] = w.c[i];
        end
        ux = a[3] - a[0]; uy = a[4] - a[1]; uz = a[5] - a[2];
        wx = a[6] - a[0]; wy = a[7] - a[1]; wz = a[8] - a[2];
        kx = uy * wz - uz * wy;
        ky = uz * wx - ux * wz;
        kz = ux * wy - uy * wx;
        len2 = $unsigned(128'(kx) * 128'(kx) + 128'(ky) * 128'(ky) + 128'(kz) * 128'(kz));
        half_root = isqrt(len2) >> 1;
        asum = {1'b0, area_acc} + (AREA_W + 1)'(half_root);
        area_acc = (asum > {1'b0, AREA_TOP}) ? AREA_TOP : asum[AREA_W-1:0];

        trip = 128'(a[0]) * 128'(a[4] * a[8] - a[5] * a[7])
             + 128'(a[1]) * 128'(a[5] * a[6] - a[3] * a[8])
             + 128'(a[2]) * 128'(a[3] * a[7] - a[4] * a[6]);
        vsum = 128'(volume_acc) + trip;
        if (vsum > 128'sh7FFF_FFFF_FFFF_FFFF)
            volume_acc = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (vsum < -128'sh8000_0000_0000_0000)
            volume_acc = 64'sh8000_0000_0000_0000;
        else
            volume_acc = vsum[63:0];

        if (tally_acc != TALLY_TOP)
            tally_acc++;

        if (w.last)
        begin
            vmag = volume_acc[63] ? (64'd0 - volume_acc) : volume_acc;
            r.area = area_acc;
            r.volume = VOUT_W'(vmag / 64'd6);
            r.count = tally_acc;
            expected_meshes.insert(expected_meshes.size(), r);
            area_acc = '0;
            volume_acc = '0;
            tally_acc = '0;
        end
    endtask

    function automatic tri_word_t random_word(int scale, logic last);
        tri_word_t w;
        for (int i = 0; i < 9; i++)
        begin
            case (scale)
                0: w.c[i] = CB'($urandom);
                1: w.c[i] = CB'(int'($urandom_range(0, 2047)) - 1024);
                default: w.c[i] = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
            endcase
        end
        w.last = last;
        return w;
    endfunction

    function automatic tri_word_t fixed_word(logic signed [CB-1:0] v, logic last);
        tri_word_t w;
        for (int i = 0; i < 9; i++)
        begin
            w.c[i] = v;
        end
        w.last = last;
        return w;
    endfunction

    // stimulus fill: directed meshes first, then random meshes
    initial begin
        tri_word_t w;
        int mesh_len;
        // degenerate triangles and a single-triangle mesh
        pending_words.insert(pending_words.size(), fixed_word('0, 1'b1));
        pending_words.insert(pending_words.size(), fixed_word(16'sh7FFF, 1'b0));
        pending_words.insert(pending_words.size(), fixed_word(-16'sh8000, 1'b1));
        // right triangle at the origin, then two more faces closing a three-triangle mesh
        w = fixed_word('0, 1'b0); w.c[3] = 16'sh0100; w.c[7] = 16'sh0100;
        pending_words.insert(pending_words.size(), w);
        w = fixed_word('0, 1'b0); w.c[3] = 16'sh0100; w.c[8] = 16'sh0100;
        w.c[2] = 16'sh0100; w.c[5] = -16'sh0100;
        pending_words.insert(pending_words.size(), w);
        w.last = 1'b1; w.c[0] = 16'sh1234;
        pending_words.insert(pending_words.size(), w);
        // extreme corners: largest cross and triple products
        for (int k = 0; k < 8; k++)
        begin
            w = fixed_word('0, k == 7);
            w.c[0] = -16'sh8000; w.c[1] = 16'sh7FFF; w.c[2] = -16'sh8000;
            w.c[3] = 16'sh7FFF; w.c[4] = -16'sh8000; w.c[5] = -16'sh8000;
            w.c[6] = -16'sh8000; w.c[7] = -16'sh8000; w.c[8] = 16'sh7FFF;
            if (k[0])
            begin
                w.c[6] = 16'sh7FFF;
            end
            pending_words.insert(pending_words.size(), w);
        end
        for (int k = 0; k < 6; k++)
        begin
            pending_words.insert(pending_words.size(), random_word(2, k == 5));
        end
        // random meshes, mostly short, some long; some words with extreme coordinates
        while (pending_words.size() < 1020)
        begin
            mesh_len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            for (int k = 0; k < mesh_len; k++)
            begin
                pending_words.insert(pending_words.size(),
                    random_word($urandom_range(0, 9) == 0 ? 2 : $urandom_range(0, 1),
                                k == mesh_len - 1));
            end
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            last_triangle <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                vtx[i] <= '0;
            end
        end
        else
        begin
            if (push && !full)
            begin
                accumulate_triangle(pending_words.pop_front());
            end
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                push <= 1'b1;
                for (int i = 0; i < 9; i++)
                begin
                    vtx[i] <= pending_words[0].c[i];
                end
                last_triangle <= pending_words[0].last;
            end
            else
            begin
                push <= 1'b0;
                for (int i = 0; i < 9; i++)
                begin
                    vtx[i] <= CB'($urandom);
                end
                last_triangle <= 1'($urandom);
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        mesh_result_t e;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_meshes.size() == 0)
                begin
                    $error("unexpected result word area=%0d", total_area);
                    errors++;
                end
                else
                begin
                    e = expected_meshes.pop_front();
                    if (total_area !== e.area)
                    begin
                        $error("total_area expected %0d actual %0d", e.area, total_area);
                        errors++;
                    end
                    if (total_volume !== e.volume)
                    begin
                        $error("total_volume expected %0d actual %0d", e.volume,
                               total_volume);
                        errors++;
                    end
                    if (triangle_total !== e.count)
                    begin
                        $error("triangle_total expected %0d actual %0d", e.count,
                               triangle_total);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // idling phases, then drain and finish
    initial begin
        int total;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_words.size() > 0);
        total = pending_words.size();
        while (pending_words.size() > 0)
        begin
            @(posedge clk);
            case ((total - pending_words.size()) * 5 / total)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                3: begin send_idle_pct = 37; recv_stall_pct = 37; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
        end
        while (expected_meshes.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_meshes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hdl/mava_pkg.sv
hdl/mava_front.sv
hdl/mava_queue.sv
hdl/mava_back.sv
hdl/mesh_area_volume_accumulator_top.sv
test/tb_top.sv
